/* rtl/core/dspt_pkg.sv */
// Package for the deck status packet tracker: constants, offsets and shared types.
// No dependencies.
package dspt_pkg;

  localparam int NumDecksDef = 6;
  localparam int MaxPacketBytesDef = 2048;

  localparam logic [15:0] StaleLimitRst   = 16'd10000;
  localparam logic [15:0] ReceiveLimitRst = 16'd5000;
  localparam logic [10:0] MinLengthRst    = 11'd164;
  localparam logic [7:0]  SubtypeRst      = 8'd3;

  localparam int OfsSubtype = 'h0a;
  localparam int OfsPlayer  = 'h21;
  localparam int OfsTrack   = 'h2c;
  localparam int OfsFlags   = 'h89;
  localparam int OfsBpm     = 'h92;
  localparam int FlagMaster  = 5;
  localparam int FlagPlaying = 6;
  localparam logic [15:0] AgeMax = 16'hffff;

  // Register indexes on the configuration port
  localparam logic [1:0] CfgStale   = 2'd0;
  localparam logic [1:0] CfgReceive = 2'd1;
  localparam logic [1:0] CfgMinLen  = 2'd2;
  localparam logic [1:0] CfgSubtype = 2'd3;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0: m = 8'h51;
      4'd1: m = 8'h73;
      4'd2: m = 8'h70;
      4'd3: m = 8'h74;
      4'd4: m = 8'h31;
      4'd5: m = 8'h57;
      4'd6: m = 8'h6d;
      4'd7: m = 8'h4a;
      4'd8: m = 8'h4f;
      4'd9: m = 8'h4c;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Classified item handed from front to back
  typedef struct packed {
    logic        tick;
    logic        commit;
    logic [2:0]  player;
    logic [31:0] track;
    logic [15:0] bpm;
    logic        playing;
    logic        master;
  } cmd_t;

endpackage

/* rtl/core/dspt_front.sv */
// Front part: byte capture at fixed offsets and the commit checks.
// Depends on dspt_pkg.
module dspt_front #(
  parameter int NUM_DECKS        = dspt_pkg::NumDecksDef,
  parameter int MAX_PACKET_BYTES = dspt_pkg::MaxPacketBytesDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic             opcode,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [10:0]      min_len,
  input  logic [7:0]       subtype,
  output dspt_pkg::cmd_t   cmd
);
  import dspt_pkg::*;

  localparam int OW = $clog2(MAX_PACKET_BYTES);

  logic [OW-1:0] ofs_r, ofs_nxt;
  logic          magic_r, magic_nxt;
  logic          sub_r, sub_nxt;
  logic [7:0]    player_r, player_nxt;
  logic [31:0]   track_r, track_nxt;
  logic [15:0]   bpm_r, bpm_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [OW:0]   length;
  logic          len_ok, pl_ok;

  // Capture of the current byte, combined with held values
  always_comb begin
    magic_nxt  = magic_r;
    sub_nxt    = sub_r;
    player_nxt = player_r;
    track_nxt  = track_r;
    bpm_nxt    = bpm_r;
    flags_nxt  = flags_r;
    if (ofs_r == '0) begin
      magic_nxt  = 1'b1;
      sub_nxt    = 1'b0;
      player_nxt = '0;
      track_nxt  = '0;
      bpm_nxt    = '0;
      flags_nxt  = '0;
    end
    if (ofs_r < OW'(10) && data_byte != magic_byte(ofs_r[3:0])) magic_nxt = 1'b0;
    if (ofs_r == OW'(OfsSubtype)) sub_nxt = (data_byte == subtype);
    if (ofs_r == OW'(OfsPlayer)) player_nxt = data_byte;
    if (ofs_r == OW'(OfsTrack))     track_nxt[31:24] = data_byte;
    if (ofs_r == OW'(OfsTrack + 1)) track_nxt[23:16] = data_byte;
    if (ofs_r == OW'(OfsTrack + 2)) track_nxt[15:8]  = data_byte;
    if (ofs_r == OW'(OfsTrack + 3)) track_nxt[7:0]   = data_byte;
    if (ofs_r == OW'(OfsFlags)) flags_nxt = data_byte;
    if (ofs_r == OW'(OfsBpm))     bpm_nxt[15:8] = data_byte;
    if (ofs_r == OW'(OfsBpm + 1)) bpm_nxt[7:0]  = data_byte;

    if (last_byte) ofs_nxt = '0;
    else if (ofs_r != OW'(MAX_PACKET_BYTES - 1)) ofs_nxt = ofs_r + 1'b1;
    else ofs_nxt = ofs_r;
  end

  // Commit checks on the last byte
  assign length = {1'b0, ofs_r} + 1'b1;
  assign len_ok = (12'(length) >= {1'b0, min_len});
  assign pl_ok  = (player_nxt != 8'd0) && (player_nxt <= 8'(NUM_DECKS));

  always_comb begin
    cmd         = '0;
    cmd.tick    = (opcode == OpTick);
    cmd.commit  = (opcode == OpByte) && last_byte && len_ok && magic_nxt && sub_nxt && pl_ok;
    cmd.player  = player_nxt[2:0];
    cmd.track   = track_nxt;
    cmd.bpm     = (bpm_nxt == 16'hffff) ? 16'd0 : bpm_nxt;
    cmd.playing = flags_nxt[FlagPlaying];
    cmd.master  = flags_nxt[FlagMaster];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r    <= '0;
      magic_r  <= 1'b1;
      sub_r    <= 1'b0;
      player_r <= '0;
      track_r  <= '0;
      bpm_r    <= '0;
      flags_r  <= '0;
    end else if (take && opcode == OpByte) begin
      ofs_r    <= ofs_nxt;
      magic_r  <= magic_nxt;
      sub_r    <= sub_nxt;
      player_r <= player_nxt;
      track_r  <= track_nxt;
      bpm_r    <= bpm_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

/* rtl/core/dspt_queue.sv */
// Two-entry queue between front and back parts.
// Depends on dspt_pkg.
module dspt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  dspt_pkg::cmd_t wr_cmd,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output dspt_pkg::cmd_t rd_cmd
);
  import dspt_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

/* rtl/core/dspt_back.sv */
// Back part: deck table, ages, now-playing selection and output register.
// Depends on dspt_pkg.
module dspt_back #(
  parameter int NUM_DECKS = dspt_pkg::NumDecksDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dspt_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [15:0]    stale_lim,
  input  logic [15:0]    recv_lim,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_now_valid,
  output logic [2:0]     out_now_deck,
  output logic [31:0]    out_now_track_id,
  output logic [15:0]    out_now_bpm_hundredths,
  output logic           out_receiving,
  output logic           out_packet_accepted
);
  import dspt_pkg::*;

  logic [31:0] trk_r [NUM_DECKS];
  logic [15:0] bpm_r [NUM_DECKS];
  logic [15:0] age_r [NUM_DECKS];
  logic [NUM_DECKS-1:0] play_r;
  logic [2:0]  mdeck_r;
  logic [15:0] page_r;

  logic [31:0] trk_n [NUM_DECKS];
  logic [15:0] bpm_n [NUM_DECKS];
  logic [15:0] age_n [NUM_DECKS];
  logic [NUM_DECKS-1:0] play_n;
  logic [2:0]  mdeck_n;
  logic [15:0] page_n;
  logic [2:0]  sel;
  logic        sel_ok;
  logic        ovalid_r;
  logic        go;

  assign go = q_valid && (!ovalid_r || !out_stall);
  assign q_pop = go;
  assign out_valid = ovalid_r;

  // Next deck state for the item at the queue head
  always_comb begin
    mdeck_n = mdeck_r;
    page_n  = page_r;
    play_n  = play_r;
    for (int i = 0; i < NUM_DECKS; i++) begin
      trk_n[i] = trk_r[i];
      bpm_n[i] = bpm_r[i];
      age_n[i] = age_r[i];
      if (q_cmd.tick && age_r[i] != AgeMax) age_n[i] = age_r[i] + 1'b1;
      if (q_cmd.commit && q_cmd.player == 3'(i + 1)) begin
        trk_n[i]  = q_cmd.track;
        bpm_n[i]  = q_cmd.bpm;
        play_n[i] = q_cmd.playing;
        age_n[i]  = '0;
      end
    end
    if (q_cmd.tick && page_r != AgeMax) page_n = page_r + 1'b1;
    if (q_cmd.commit) begin
      page_n = '0;
      if (q_cmd.master) mdeck_n = q_cmd.player;
    end
  end

  // Now-playing selection on the updated state
  always_comb begin
    sel = mdeck_n;
    if (sel == 3'd0) begin
      for (int i = NUM_DECKS - 1; i >= 0; i--)
        if (play_n[i] && trk_n[i] != '0) sel = 3'(i + 1);
    end
    sel_ok = 1'b0;
    for (int i = 0; i < NUM_DECKS; i++)
      if (sel == 3'(i + 1)) sel_ok = (trk_n[i] != '0) && (age_n[i] <= stale_lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DECKS; i++) begin
        trk_r[i] <= '0;
        bpm_r[i] <= '0;
        age_r[i] <= AgeMax;
      end
      play_r   <= '0;
      mdeck_r  <= '0;
      page_r   <= AgeMax;
      ovalid_r <= 1'b0;
    end else begin
      if (go) begin
        for (int i = 0; i < NUM_DECKS; i++) begin
          trk_r[i] <= trk_n[i];
          bpm_r[i] <= bpm_n[i];
          age_r[i] <= age_n[i];
        end
        play_r  <= play_n;
        mdeck_r <= mdeck_n;
        page_r  <= page_n;
      end
      if (go) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (go) begin
      out_now_valid       <= sel_ok;
      out_now_deck        <= sel_ok ? sel : 3'd0;
      out_now_track_id    <= '0;
      out_now_bpm_hundredths <= '0;
      for (int i = 0; i < NUM_DECKS; i++)
        if (sel_ok && sel == 3'(i + 1)) begin
          out_now_track_id       <= trk_n[i];
          out_now_bpm_hundredths <= bpm_n[i];
        end
      out_receiving       <= (page_n < recv_lim);
      out_packet_accepted <= q_cmd.commit;
    end
  end

endmodule

/* rtl/core/deck_status_packet_tracker.sv */
// Top level of the deck status packet tracker: config registers, front, queue, back.
// Depends on dspt_pkg, dspt_front, dspt_queue, dspt_back.
//
//  channel | ports                                   | direction
//  in      | in_valid/in_stall, opcode, byte, last   | item in
//  out     | out_valid/out_stall, six result fields  | item out
//  cfg     | cfg_we, cfg_index, cfg_data             | register write
//
// One item per cycle unless out_stall or a full queue holds it off: capture, then deck
// update into the result register. A two-entry queue between capture and deck table
// lets the front keep accepting while a result waits; in_stall rises when it is full.
// Synchronous active-low reset clears the capture state, deck table and ages.
module deck_status_packet_tracker #(
  parameter int NUM_DECKS        = dspt_pkg::NumDecksDef,
  parameter int MAX_PACKET_BYTES = dspt_pkg::MaxPacketBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_now_valid,
  output logic [2:0]  out_now_deck,
  output logic [31:0] out_now_track_id,
  output logic [15:0] out_now_bpm_hundredths,
  output logic        out_receiving,
  output logic        out_packet_accepted,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dspt_pkg::*;

  logic [15:0] stale_r, recv_r;
  logic [10:0] minlen_r;
  logic [7:0]  sub_r;
  logic        take, full, q_valid, q_pop;
  cmd_t        f_cmd, q_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r  <= StaleLimitRst;
      recv_r   <= ReceiveLimitRst;
      minlen_r <= MinLengthRst;
      sub_r    <= SubtypeRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgStale:   stale_r  <= cfg_data;
        CfgReceive: recv_r   <= cfg_data;
        CfgMinLen:  minlen_r <= cfg_data[10:0];
        CfgSubtype: sub_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign take = in_valid && !full;

  dspt_front #(.NUM_DECKS(NUM_DECKS), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk, .rst_n, .take,
    .opcode(in_opcode), .data_byte(in_data_byte), .last_byte(in_last_byte),
    .min_len(minlen_r), .subtype(sub_r), .cmd(f_cmd)
  );

  dspt_queue u_queue (
    .clk, .rst_n, .wr_en(take), .wr_cmd(f_cmd), .full,
    .rd_valid(q_valid), .rd_en(q_pop), .rd_cmd(q_cmd)
  );

  dspt_back #(.NUM_DECKS(NUM_DECKS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .stale_lim(stale_r), .recv_lim(recv_r),
    .out_valid, .out_stall, .out_now_valid, .out_now_deck, .out_now_track_id,
    .out_now_bpm_hundredths, .out_receiving, .out_packet_accepted
  );

`ifndef SYNTHESIS
  // A stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_now_track_id))
    else $error("result changed under stall");
  // A valid now-playing report names a deck
  a_deck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_now_valid |-> out_now_deck != 3'd0)
    else $error("valid report without deck");
  // Accepted packets make the block receiving unless the receive limit is zero
  a_recv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_accepted && recv_r != 16'd0 |-> out_receiving)
    else $error("accepted packet not receiving");
`endif

endmodule

/* tb/sv/tb_deck_status_packet_tracker.sv */
// Testbench for deck_status_packet_tracker: directed cases, then random packets and ticks,
// with every result checked against a cycle-free predictor. Depends on dspt_pkg and the RTL.
module tb_deck_status_packet_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import dspt_pkg::*;

  localparam int NDECK = 6;
  localparam int MAXLEN = 2048;

  typedef struct packed {
    logic        now_valid;
    logic [2:0]  now_deck;
    logic [31:0] now_track;
    logic [15:0] now_bpm;
    logic        receiving;
    logic        accepted;
  } status_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       last;
    logic       chk;
    status_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_opcode = 1'b0, in_last_byte = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic in_stall, out_valid, out_stall = 1'b0;
  logic out_now_valid, out_receiving, out_packet_accepted;
  logic [2:0] out_now_deck;
  logic [31:0] out_now_track_id;
  logic [15:0] out_now_bpm_hundredths;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  deck_status_packet_tracker dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL deck_status_packet_tracker");
    $finish;
  end

  // predictor state
  logic [15:0] stale_lim, recv_lim;
  logic [10:0] min_len;
  logic [7:0]  subtype;
  int unsigned ofs;
  logic mag_ok, sub_ok;
  logic [7:0] cap_player, cap_flags;
  logic [31:0] cap_track;
  logic [15:0] cap_bpm;
  logic [31:0] trk [NDECK];
  logic [15:0] bpm [NDECK];
  logic play [NDECK], mst [NDECK];
  logic [15:0] age [NDECK];
  int unsigned master_no;
  logic [15:0] pkt_age;

  status_t status_q[$];
  int errors = 0;
  int mism = 0;
  int idle_in = 0, idle_out = 0;
  int hold_len = 0;
  logic hold_on = 1'b0;

  function automatic logic [7:0] sync_byte(int i);
    logic [7:0] m [10] = '{8'h51, 8'h73, 8'h70, 8'h74, 8'h31,
                           8'h57, 8'h6d, 8'h4a, 8'h4f, 8'h4c};
    return m[i];
  endfunction

  task automatic tracker_reset();
    stale_lim = 16'd10000; recv_lim = 16'd5000; min_len = 11'd164; subtype = 8'd3;
    ofs = 0; mag_ok = 1; sub_ok = 0;
    cap_player = 0; cap_flags = 0; cap_track = 0; cap_bpm = 0;
    for (int i = 0; i < NDECK; i++) begin
      trk[i] = 0; bpm[i] = 0; play[i] = 0; mst[i] = 0; age[i] = 16'hffff;
    end
    master_no = 0; pkt_age = 16'hffff;
  endtask

  // one item through the predictor
  function automatic status_t track_status(logic op, logic [7:0] b, logic last);
    status_t s;
    logic acc;
    int unsigned len, p, d;
    acc = 0;
    if (op == OpTick) begin
      for (int i = 0; i < NDECK; i++) if (age[i] != 16'hffff) age[i]++;
      if (pkt_age != 16'hffff) pkt_age++;
    end else begin
      len = ofs + 1;
      if (ofs == 0) begin
        mag_ok = 1; sub_ok = 0; cap_player = 0; cap_track = 0; cap_bpm = 0; cap_flags = 0;
      end
      if (ofs < 10 && b != sync_byte(int'(ofs))) mag_ok = 0;
      if (ofs == OfsSubtype) sub_ok = (b == subtype);
      if (ofs == OfsPlayer) cap_player = b;
      if (ofs >= OfsTrack && ofs < OfsTrack + 4) cap_track[8*(OfsTrack+3-ofs) +: 8] = b;
      if (ofs == OfsFlags) cap_flags = b;
      if (ofs == OfsBpm) cap_bpm[15:8] = b;
      if (ofs == OfsBpm + 1) cap_bpm[7:0] = b;
      if (last) begin
        if (len >= min_len && mag_ok && sub_ok && cap_player >= 1 && cap_player <= NDECK) begin
          d = cap_player - 1;
          trk[d] = cap_track;
          bpm[d] = (cap_bpm == 16'hffff) ? 16'h0 : cap_bpm;
          play[d] = cap_flags[FlagPlaying];
          mst[d] = cap_flags[FlagMaster];
          age[d] = 0; pkt_age = 0;
          if (mst[d]) master_no = cap_player;
          acc = 1;
        end
        ofs = 0;
      end else if (ofs < MAXLEN - 1) ofs++;
    end
    p = master_no;
    if (p == 0) begin
      for (int i = NDECK - 1; i >= 0; i--) if (play[i] && trk[i] != 0) p = i + 1;
    end
    s = '0;
    if (p != 0 && trk[p-1] != 0 && age[p-1] <= stale_lim) begin
      s.now_valid = 1; s.now_deck = p[2:0]; s.now_track = trk[p-1]; s.now_bpm = bpm[p-1];
    end
    s.receiving = pkt_age < recv_lim;
    s.accepted = acc;
    return s;
  endfunction

  // sender: hold one item until accepted
  task automatic send_item(logic op, logic [7:0] b, logic last);
    while (idle_in > 0 && int'($urandom_range(99)) < idle_in) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_opcode <= op; in_data_byte <= b; in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_q.push_back(track_status(op, b, last));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      CfgStale: stale_lim = v;
      CfgReceive: recv_lim = v;
      CfgMinLen: min_len = v[10:0];
      CfgSubtype: subtype = v[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (status_q.size() != 0 && n < 200000) begin @(posedge clk); n++; end
    repeat (4) @(posedge clk);
  endtask

  // packet of given length with magic, subtype, player, track, flags, bpm
  task automatic send_packet(int len, logic [7:0] st, logic [7:0] pl, logic [31:0] tr,
                             logic [7:0] fl, logic [15:0] bp, int noise);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (i < 10) b = sync_byte(i);
      if (i == OfsSubtype) b = st;
      if (i == OfsPlayer) b = pl;
      if (i >= OfsTrack && i < OfsTrack + 4) b = tr[8*(OfsTrack+3-i) +: 8];
      if (i == OfsFlags) b = fl;
      if (i == OfsBpm) b = bp[15:8];
      if (i == OfsBpm + 1) b = bp[7:0];
      if (noise > 0 && int'($urandom_range(99)) < noise) b = 8'($urandom_range(255));
      send_item(OpByte, b, i == len - 1);
    end
  endtask

  // long receiver hold-off, counted in its own process
  initial begin
    wait (hold_len > 0);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (hold_len) @(posedge clk);
    hold_on <= 1'b0;
  end

  // receiver: stall pattern and checking
  always @(posedge clk) begin
    status_t got, exp_s;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_now_valid, out_now_deck, out_now_track_id, out_now_bpm_hundredths,
               out_receiving, out_packet_accepted};
        if (status_q.size() == 0) begin
          errors++;
          if (mism < 10) $display("unexpected result %h", got);
          mism++;
        end else begin
          exp_s = status_q.pop_front();
          if (got !== exp_s) begin
            errors++;
            if (mism < 10) $display("mismatch: expected %h actual %h", exp_s, got);
            mism++;
          end
        end
      end
      out_stall <= hold_on || ((idle_out > 0) && (int'($urandom_range(99)) < idle_out));
    end
  end

  row_t dir_rows[$];

  initial begin
    status_t z;
    logic [7:0] pl, st, fl;
    logic [31:0] tr;
    logic [15:0] bp;
    logic must_m;
    int len;
    tracker_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table: after reset, ticks, one-byte packets
    z = '0;
    dir_rows.push_back('{OpTick, 8'h00, 1'b0, 1'b1, z});
    dir_rows.push_back('{OpByte, 8'hff, 1'b1, 1'b1, z});
    dir_rows.push_back('{OpByte, 8'h51, 1'b1, 1'b1, z});
    dir_rows.push_back('{OpTick, 8'hff, 1'b1, 1'b1, z});
    foreach (dir_rows[i]) begin
      status_t w;
      w = track_status(dir_rows[i].op, dir_rows[i].data, dir_rows[i].last);
      status_q.push_back(w);
      in_valid <= 1; in_opcode <= dir_rows[i].op;
      in_data_byte <= dir_rows[i].data; in_last_byte <= dir_rows[i].last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (dir_rows[i].chk && w !== dir_rows[i].want) begin
        errors++;
        $display("directed row %0d disagrees with table", i);
      end
    end
    // shortest packet at reset limits: playing deck, extreme track, bpm 0xffff
    send_packet(164, 8'd3, 8'd2, 32'hffffffff, 8'h40, 16'hffff, 0);
    drain();

    // player out of range, wrong subtype
    write_reg(CfgMinLen, 16'd0);
    send_packet(34, 8'd3, 8'd7, 32'h5, 8'h60, 16'd100, 0);
    send_packet(34, 8'd4, 8'd1, 32'h5, 8'h60, 16'd100, 0);
    drain();
    // one byte below and at the length limit
    write_reg(CfgMinLen, 16'd35);
    send_packet(34, 8'd3, 8'd3, 32'h1, 8'h00, 16'd0, 0);
    send_packet(35, 8'd3, 8'd3, 32'h1, 8'h00, 16'd0, 0);
    drain();

    // limit extremes
    write_reg(CfgStale, 16'd0);
    write_reg(CfgReceive, 16'd65534);
    write_reg(CfgSubtype, 16'd255);
    send_item(OpTick, 8'h00, 1'b0);
    send_item(OpTick, 8'h00, 1'b1);
    drain();
    write_reg(CfgStale, 16'd65534);
    write_reg(CfgReceive, 16'd0);
    write_reg(CfgMinLen, 16'd2047);
    send_packet(34, 8'd255, 8'd4, 32'habcdef01, 8'h40, 16'd1, 0);
    send_item(OpTick, 8'h00, 1'b0);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_in = 0; idle_out = 0; end
        1: begin idle_in = 88; idle_out = 0; end
        2: begin idle_in = 0; idle_out = 88; end
        default: begin idle_in = 10; idle_out = 10; end
      endcase
      write_reg(CfgStale, $urandom_range(3) == 0 ? 16'd20 : 16'($urandom_range(300)));
      write_reg(CfgReceive, 16'($urandom_range(400)));
      write_reg(CfgMinLen, 16'($urandom_range(36)));
      write_reg(CfgSubtype, $urandom_range(3) == 0 ? 16'($urandom_range(255)) : 16'd3);
      if (ph == 0) hold_len = 60;
      for (int k = 0; k < 2; k++) begin
        must_m = (ph == 2 && k == 0);
        pl = $urandom_range(7) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(1, 6));
        st = $urandom_range(7) == 0 ? 8'($urandom_range(255)) : subtype;
        tr = $urandom_range(3) == 0 ? 32'd0 : 32'($urandom());
        fl = 8'($urandom_range(255));
        bp = $urandom_range(7) == 0 ? 16'hffff : 16'($urandom());
        len = int'($urandom_range(20, 38));
        if (must_m || $urandom_range(9) == 0) len = int'($urandom_range(148, 152));
        if (must_m) begin
          pl = 8'($urandom_range(1, 6)); st = subtype; fl = fl | 8'h60;
          tr = 32'($urandom_range(1, 1000));
        end
        send_packet(len, st, pl, tr, fl, bp, (!must_m && $urandom_range(9) == 0) ? 2 : 0);
        repeat ($urandom_range(1, 4))
          send_item(OpTick, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      drain();
    end

    if (errors == 0 && status_q.size() == 0) begin
      $display("PASS deck_status_packet_tracker");
    end else begin
      $display("FAIL deck_status_packet_tracker");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/dspt_pkg.sv
rtl/core/dspt_front.sv
rtl/core/dspt_queue.sv
rtl/core/dspt_back.sv
rtl/core/deck_status_packet_tracker.sv
tb/sv/tb_deck_status_packet_tracker.sv
